[rtl/core/mbe_pkg.sv]
// Shared types for the escape-time pixel colorer: register block layout and
// the command and status words that join the controller and the datapath.
// No dependencies.
package mbe_pkg;

  // configuration register block
  typedef struct packed {
    logic [15:0] max_iterations;
    logic        gradient_enable;
    logic [23:0] body_color;
    logic [23:0] background_color;
    logic [23:0] gradient_color;
    logic [19:0] pixel_step;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture pixel indices, clear count and flag
    logic coord;      // form c from the indices
    logic init_z;     // z = c, start squaring c
    logic sq_done;    // capture squares of c
    logic step_a;     // start cross product and new real square
    logic a_done;     // capture new imaginary part and real square
    logic step_b;     // start new imaginary square
    logic b_done;     // capture imaginary square
    logic next_iter;  // advance iteration index
    logic set_esc;    // mark pixel escaped
    logic div_start;  // start gradient weight division
    logic blend;      // form per-channel blend sums
    logic out_load;   // load result word into output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic lim_zero;   // effective limit is zero
    logic far;        // c lies outside the radius-4 box
    logic mul_done;   // multipliers finished
    logic esc_hit;    // |z|^2 above 4
    logic last_iter;  // index is limit - 1
    logic div_done;   // weight division finished
    logic grad_en;    // gradient blending on
    logic out_free;   // output register can take a word
  } sts_t;

endpackage

[rtl/core/mbe_mul.sv]
// Sequential signed fixed-point multiplier: four half-width partial products
// accumulated one per pass, result floor(a*b / 2^FRAC).
// Depends on nothing.
module mbe_mul #(
  parameter int FRAC = 28
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [FRAC+7:0] a,
  input  logic signed [FRAC+7:0] b,
  output logic                   done,
  output logic signed [FRAC+12:0] result
);

  localparam int OW = FRAC + 8;
  localparam int MB = OW - 1;
  localparam int H  = (MB + 1) / 2;
  localparam int AW = 4 * H;
  localparam int QW = AW - FRAC;
  localparam int RW = FRAC + 13;

  logic [OW-1:0]  a_abs, b_abs;
  logic [2*H-1:0] amag, bmag;
  logic           neg;
  logic [AW-1:0]  acc;
  logic [1:0]     cnt;
  logic           busy;
  logic [H-1:0]   op_x, op_y;
  logic [2*H-1:0] pp;
  logic [AW-1:0]  pp_sh;
  logic [QW-1:0]  q_adj, q_sgn;

  // operand magnitudes
  assign a_abs = a[OW-1] ? OW'(-a) : OW'(a);
  assign b_abs = b[OW-1] ? OW'(-b) : OW'(b);

  // partial product select
  always_comb begin
    op_x  = amag[H-1:0];
    op_y  = bmag[H-1:0];
    pp    = (2*H)'(op_x) * (2*H)'(op_y);
    pp_sh = AW'(pp);
    unique case (cnt)
      2'd0: begin
        op_x  = amag[H-1:0];
        op_y  = bmag[H-1:0];
        pp    = (2*H)'(op_x) * (2*H)'(op_y);
        pp_sh = AW'(pp);
      end
      2'd1: begin
        op_x  = amag[H-1:0];
        op_y  = bmag[2*H-1:H];
        pp    = (2*H)'(op_x) * (2*H)'(op_y);
        pp_sh = AW'(pp) << H;
      end
      2'd2: begin
        op_x  = amag[2*H-1:H];
        op_y  = bmag[H-1:0];
        pp    = (2*H)'(op_x) * (2*H)'(op_y);
        pp_sh = AW'(pp) << H;
      end
      default: begin
        op_x  = amag[2*H-1:H];
        op_y  = bmag[2*H-1:H];
        pp    = (2*H)'(op_x) * (2*H)'(op_y);
        pp_sh = AW'(pp) << (2 * H);
      end
    endcase
  end

  // operand capture and accumulation
  always_ff @(posedge clk) begin
    if (start) begin
      amag <= (2*H)'(a_abs[MB-1:0]);
      bmag <= (2*H)'(b_abs[MB-1:0]);
      neg  <= a[OW-1] ^ b[OW-1];
      acc  <= '0;
    end else if (busy) begin
      acc <= acc + pp_sh;
    end
  end

  // pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 2'd1;
      if (cnt == 2'd3) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // scale back, rounding toward minus infinity
  assign q_adj  = acc[AW-1:FRAC] + QW'(|acc[FRAC-1:0] & neg);
  assign q_sgn  = neg ? (~q_adj + QW'(1)) : q_adj;
  assign result = signed'(q_sgn[RW-1:0]);

endmodule

[rtl/core/mbe_datapath.sv]
// Datapath of the escape-time pixel colorer: coordinate mapping, z registers,
// two sequential multipliers, weight divider, color blend and output register.
// Depends on mbe_pkg and mbe_mul.
module mbe_datapath
  import mbe_pkg::*;
#(
  parameter int FRAC      = 28,
  parameter int ITER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic [13:0] column,
  input  logic [13:0] pixel_row,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic        inside_set,
  output logic [15:0] escape_count
);

  localparam int OW  = FRAC + 8;
  localparam int RW  = FRAC + 13;
  localparam int CXW = ((34 > FRAC + 2) ? 34 : FRAC + 2) + 1;
  localparam int LW  = (ITER_BITS > 16) ? ITER_BITS : 16;
  localparam int DW  = ITER_BITS + 8;

  localparam logic signed [CXW-1:0] ONE_CX      = CXW'(1) << FRAC;
  localparam logic signed [CXW-1:0] TWO_CX      = CXW'(2) << FRAC;
  localparam logic signed [CXW-1:0] FOUR_CX     = CXW'(4) << FRAC;
  localparam logic signed [CXW-1:0] NEG_FOUR_CX = -FOUR_CX;
  localparam logic signed [RW-1:0]  FOUR_RW     = RW'(4) << FRAC;
  localparam logic signed [RW:0]    FOUR_SUM    = (RW+1)'(4) << FRAC;
  localparam logic [LW-1:0]         LIM_CAP     = LW'({ITER_BITS{1'b1}});

  // truncating blend of two 8-bit channels weighted by n out of 255
  function automatic logic [15:0] blend_sum(input logic [7:0] n, input logic [7:0] g,
                                            input logic [7:0] bg);
    return 16'(n) * 16'(g) + 16'(8'd255 - n) * 16'(bg);
  endfunction

  // divide by 255 for values below 255*256: shift estimate plus one correction
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [7:0] q0;
    logic [8:0] r;
    q0 = x[15:8];
    r  = {1'b0, x[7:0]} + {1'b0, q0};
    return (r >= 9'd255) ? q0 + 8'd1 : q0;
  endfunction

  logic [13:0]           col_r, row_r;
  logic [33:0]           col_prod, row_prod;
  logic signed [CXW-1:0] cx, cy, cx_next, cy_next;
  logic signed [OW-1:0]  cx_z, cy_z;
  logic signed [OW-1:0]  re, im, re2, nr, ni;
  logic signed [RW-1:0]  sqre, sqim, nr_full, ni_full;
  logic signed [RW:0]    mag_sum;
  logic [ITER_BITS-1:0]  iter, limit;
  logic [LW-1:0]         mi_ext;
  logic                  esc;

  logic                  u0_start, u1_start, u0_done, u1_done;
  logic signed [OW-1:0]  u0_a, u0_b, u1_a, u1_b;
  logic signed [RW-1:0]  u0_res, u1_res;

  logic [DW-1:0]         div_rem, div_dvs;
  logic [7:0]            div_q;
  logic [2:0]            div_cnt;
  logic                  div_busy, div_done;

  logic [15:0]           blend_x [3];
  logic [23:0]           color;

  // effective iteration limit
  assign mi_ext = LW'(cfg.max_iterations);
  assign limit  = ITER_BITS'((mi_ext > LIM_CAP) ? LIM_CAP : mi_ext);

  // pixel to complex point
  assign col_prod = 34'(col_r) * 34'(cfg.pixel_step);
  assign row_prod = 34'(row_r) * 34'(cfg.pixel_step);
  assign cx_next  = $signed({{(CXW-34){1'b0}}, col_prod}) - TWO_CX;
  assign cy_next  = $signed({{(CXW-34){1'b0}}, row_prod}) - ONE_CX;
  assign cx_z     = OW'(cx);
  assign cy_z     = OW'(cy);

  // iteration arithmetic
  assign re2     = {re[OW-2:0], 1'b0};
  assign nr_full = sqre - sqim + RW'(cx_z);
  assign nr      = OW'(nr_full);
  assign ni_full = u0_res + RW'(cy_z);
  assign ni      = OW'(ni_full);
  assign mag_sum = (RW+1)'(sqre) + (RW+1)'(sqim);

  // multiplier operand steering
  assign u0_start = cmd.init_z | cmd.step_a;
  assign u1_start = cmd.init_z | cmd.step_a | cmd.step_b;
  assign u0_a     = cmd.init_z ? cx_z : re2;
  assign u0_b     = cmd.init_z ? cx_z : im;
  assign u1_a     = cmd.init_z ? cy_z : (cmd.step_a ? nr : im);
  assign u1_b     = u1_a;

  mbe_mul #(.FRAC(FRAC)) u_mul0 (
    .clk    (clk),
    .rst    (rst),
    .start  (u0_start),
    .a      (u0_a),
    .b      (u0_b),
    .done   (u0_done),
    .result (u0_res)
  );

  mbe_mul #(.FRAC(FRAC)) u_mul1 (
    .clk    (clk),
    .rst    (rst),
    .start  (u1_start),
    .a      (u1_a),
    .b      (u1_b),
    .done   (u1_done),
    .result (u1_res)
  );

  // coordinate and z registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r <= column;
      row_r <= pixel_row;
    end
    if (cmd.coord) begin
      cx <= cx_next;
      cy <= cy_next;
    end
    if (cmd.init_z) begin
      re <= cx_z;
      im <= cy_z;
    end
    if (cmd.sq_done) begin
      sqre <= u0_res;
      sqim <= u1_res;
    end
    if (cmd.step_a) begin
      re <= nr;
    end
    if (cmd.a_done) begin
      im   <= ni;
      sqre <= u1_res;
    end
    if (cmd.b_done) begin
      sqim <= u1_res;
    end
  end

  // iteration index and escape flag
  always_ff @(posedge clk) begin
    if (rst) begin
      iter <= '0;
      esc  <= 1'b0;
    end else begin
      if (cmd.load) begin
        iter <= '0;
        esc  <= 1'b0;
      end
      if (cmd.next_iter) begin
        iter <= iter + ITER_BITS'(1);
      end
      if (cmd.set_esc) begin
        esc <= 1'b1;
      end
    end
  end

  // gradient weight: restoring division of i*255 by the limit, one bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_rem <= {iter, 8'b0} - DW'(iter);
      div_dvs <= {1'b0, limit, 7'b0};
      div_q   <= '0;
    end else if (div_busy) begin
      if (div_rem >= div_dvs) begin
        div_rem <= div_rem - div_dvs;
        div_q   <= {div_q[6:0], 1'b1};
      end else begin
        div_q <= {div_q[6:0], 1'b0};
      end
      div_dvs <= div_dvs >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done <= 1'b0;
      div_cnt  <= '0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
      div_done <= 1'b0;
      div_cnt  <= '0;
    end else if (div_busy) begin
      div_cnt <= div_cnt + 3'd1;
      if (div_cnt == 3'd7) begin
        div_busy <= 1'b0;
        div_done <= 1'b1;
      end
    end else begin
      div_done <= 1'b0;
    end
  end

  // per-channel blend sums
  always_ff @(posedge clk) begin
    if (cmd.blend) begin
      for (int k = 0; k < 3; k++) begin
        blend_x[k] <= blend_sum(div_q, cfg.gradient_color[8*k +: 8],
                                cfg.background_color[8*k +: 8]);
      end
    end
  end

  // final color select
  always_comb begin
    if (!esc) begin
      color = cfg.body_color;
    end else if (!cfg.gradient_enable) begin
      color = cfg.background_color;
    end else begin
      color = {div255(blend_x[2]), div255(blend_x[1]), div255(blend_x[0])};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      red          <= color[23:16];
      green        <= color[15:8];
      blue         <= color[7:0];
      inside_set   <= ~esc;
      escape_count <= esc ? 16'(iter) : 16'd0;
    end
  end

  // status to controller
  assign sts.lim_zero  = (limit == '0);
  assign sts.far       = (cx > FOUR_CX) || (cx < NEG_FOUR_CX) ||
                         (cy > FOUR_CX) || (cy < NEG_FOUR_CX);
  assign sts.mul_done  = u1_done;
  assign sts.esc_hit   = (mag_sum > FOUR_SUM);
  assign sts.last_iter = (iter == limit - ITER_BITS'(1));
  assign sts.div_done  = div_done;
  assign sts.grad_en   = cfg.gradient_enable;
  assign sts.out_free  = ~out_valid | out_ready;

`ifndef SYNTH
  // inside points report a zero escape index
  a_inside_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && inside_set |-> escape_count == 16'd0)
    else $error("inside pixel with nonzero escape count");

  // escape index stays below the limit, so the weight stays below 255
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    div_done |-> div_q < 8'd255)
    else $error("gradient weight out of range");

  // the loop only continues from a point inside the radius-2 circle
  a_bounded_z: assert property (@(posedge clk) disable iff (rst)
    cmd.step_a && cmd.next_iter |-> sqre <= FOUR_RW && sqim <= FOUR_RW)
    else $error("iteration continued from an escaped point");
`endif

endmodule

[rtl/core/mbe_ctrl.sv]
// Controller of the escape-time pixel colorer: input handshake and the
// sequence of coordinate, iteration, weight and output steps.
// Depends on mbe_pkg.
module mbe_ctrl
  import mbe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_COORD  = 12'b0000_0000_0010,
    S_CHECK  = 12'b0000_0000_0100,
    S_SQ     = 12'b0000_0000_1000,
    S_ASTART = 12'b0000_0001_0000,
    S_ARUN   = 12'b0000_0010_0000,
    S_BSTART = 12'b0000_0100_0000,
    S_BRUN   = 12'b0000_1000_0000,
    S_TEST   = 12'b0001_0000_0000,
    S_DIV    = 12'b0010_0000_0000,
    S_BLEND  = 12'b0100_0000_0000,
    S_FIN    = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_COORD;
        end
      end
      S_COORD: begin
        cmd.coord  = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.lim_zero) begin
          state_next = S_FIN;
        end else if (sts.far) begin
          cmd.set_esc   = 1'b1;
          cmd.div_start = sts.grad_en;
          state_next    = sts.grad_en ? S_DIV : S_FIN;
        end else begin
          cmd.init_z = 1'b1;
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        if (sts.mul_done) begin
          cmd.sq_done = 1'b1;
          state_next  = S_ASTART;
        end
      end
      S_ASTART: begin
        cmd.step_a = 1'b1;
        state_next = S_ARUN;
      end
      S_ARUN: begin
        if (sts.mul_done) begin
          cmd.a_done = 1'b1;
          state_next = S_BSTART;
        end
      end
      S_BSTART: begin
        cmd.step_b = 1'b1;
        state_next = S_BRUN;
      end
      S_BRUN: begin
        if (sts.mul_done) begin
          cmd.b_done = 1'b1;
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        if (sts.esc_hit) begin
          cmd.set_esc   = 1'b1;
          cmd.div_start = sts.grad_en;
          state_next    = sts.grad_en ? S_DIV : S_FIN;
        end else if (sts.last_iter) begin
          state_next = S_FIN;
        end else begin
          cmd.next_iter = 1'b1;
          cmd.step_a    = 1'b1;
          state_next    = S_ARUN;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_BLEND;
        end
      end
      S_BLEND: begin
        cmd.blend  = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/core/mandelbrot_escape_pixel_color_unit.sv]
// Top level of the escape-time pixel colorer: APB register block, controller
// and datapath.
// Depends on mbe_pkg, mbe_ctrl, mbe_datapath.
//
//   port group   dir  handshake            word
//   pixel in     in   in_valid / in_ready   column, pixel_row
//   color out    out  out_valid / out_ready red, green, blue, inside_set, escape_count
//   registers    in   APB psel / penable    six registers at byte address 4*index
//
// One pixel is worked on at a time; the next pixel is taken while a finished
// word waits in the output register.
// The escape loop sets the time per pixel, which grows with the number of
// iterations run and is longer with gradient blending on an escaped pixel:
// each iteration runs the cross product and the two squares through two
// four-pass multipliers, the imaginary square waiting on the cross product.
// Reset is synchronous and returns the registers to their documented values;
// a stalled output holds its word and blocks only the final load.
module mandelbrot_escape_pixel_color_unit
  import mbe_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 28,
  parameter int ITER_BITS       = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [13:0] column,
  input  logic [13:0] pixel_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic        inside_set,
  output logic [15:0] escape_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] REG_MAX_ITER   = 3'd0;
  localparam logic [2:0] REG_GRAD_EN    = 3'd1;
  localparam logic [2:0] REG_BODY       = 3'd2;
  localparam logic [2:0] REG_BACKGROUND = 3'd3;
  localparam logic [2:0] REG_GRADIENT   = 3'd4;
  localparam logic [2:0] REG_STEP       = 3'd5;

  cfg_t       cfg;
  cmd_t       cmd;
  sts_t       sts;
  logic       cfg_wr;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_iterations   <= 16'd256;
      cfg.gradient_enable  <= 1'b0;
      cfg.body_color       <= 24'h000000;
      cfg.background_color <= 24'hFFFFFF;
      cfg.gradient_color   <= 24'h000000;
      cfg.pixel_step       <= 20'd524288;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MAX_ITER:   cfg.max_iterations   <= pwdata[15:0];
        REG_GRAD_EN:    cfg.gradient_enable  <= pwdata[0];
        REG_BODY:       cfg.body_color       <= pwdata[23:0];
        REG_BACKGROUND: cfg.background_color <= pwdata[23:0];
        REG_GRADIENT:   cfg.gradient_color   <= pwdata[23:0];
        REG_STEP:       cfg.pixel_step       <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      REG_MAX_ITER:   prdata = 32'(cfg.max_iterations);
      REG_GRAD_EN:    prdata = 32'(cfg.gradient_enable);
      REG_BODY:       prdata = 32'(cfg.body_color);
      REG_BACKGROUND: prdata = 32'(cfg.background_color);
      REG_GRADIENT:   prdata = 32'(cfg.gradient_color);
      REG_STEP:       prdata = 32'(cfg.pixel_step);
      default:        prdata = 32'd0;
    endcase
  end

  mbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mbe_datapath #(
    .FRAC      (COORD_FRAC_BITS),
    .ITER_BITS (ITER_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .column       (column),
    .pixel_row    (pixel_row),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .inside_set   (inside_set),
    .escape_count (escape_count)
  );

endmodule

[tb/sv/mandelbrot_escape_pixel_color_unit_tb.sv]
// Testbench for the escape-time pixel colorer: drives pixel words and APB
// register writes, predicts every color word and checks it in order.
// Depends on mbe_pkg and mandelbrot_escape_pixel_color_unit.
module mandelbrot_escape_pixel_color_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mbe_pkg::*;

  localparam int FRAC_BITS    = 28;
  localparam int IDLE_LIMIT   = 50000;
  localparam int HOLD_CYCLES  = 2000;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_PIXELS = 580;

  typedef enum int {
    REG_MAX_ITER = 0,
    REG_GRAD_EN  = 1,
    REG_BODY     = 2,
    REG_BG       = 3,
    REG_GRAD     = 4,
    REG_STEP     = 5
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        inside_set;
    logic [15:0] escape_count;
  } pixel_word_t;

  // color predictor and in-order store of expected words
  class color_scoreboard;
    cfg_t        regs;
    pixel_word_t queued[$];
    int unsigned fails;

    function new();
      regs.max_iterations   = 16'd256;
      regs.gradient_enable  = 1'b0;
      regs.body_color       = 24'h000000;
      regs.background_color = 24'hFFFFFF;
      regs.gradient_color   = 24'h000000;
      regs.pixel_step       = 20'd524288;
      fails = 0;
    endfunction

    // floor(a*b / 2^FRAC_BITS), exact
    function longint fx_mul(longint a, longint b);
      logic signed [127:0] wa, wb, p;
      wa = a;
      wb = b;
      p = wa * wb;
      return longint'(p >>> FRAC_BITS);
    endfunction

    function pixel_word_t escape_color(logic [13:0] col, logic [13:0] row);
      longint      one, four, cx, cy, re, im, nr, ni;
      int unsigned lim, i, n, g, b;
      int          s;
      bit          escaped;
      logic [23:0] rgb;
      pixel_word_t w;
      one = longint'(1) <<< FRAC_BITS;
      four = 4 * one;
      cx = longint'(col) * longint'(regs.pixel_step) - 2 * one;
      cy = longint'(row) * longint'(regs.pixel_step) - one;
      re = cx;
      im = cy;
      lim = regs.max_iterations;
      escaped = 1'b0;
      // escape loop, far points leave before any squaring
      for (i = 0; i < lim; i++) begin
        if (i == 0 && ((cx < 0 ? -cx : cx) > four || (cy < 0 ? -cy : cy) > four)) begin
          escaped = 1'b1;
          break;
        end
        nr = fx_mul(re, re) - fx_mul(im, im) + cx;
        ni = fx_mul(2 * re, im) + cy;
        re = nr;
        im = ni;
        if (fx_mul(re, re) + fx_mul(im, im) > four) begin
          escaped = 1'b1;
          break;
        end
      end
      // color selection
      if (!escaped) begin
        rgb = regs.body_color;
        i = 0;
      end else if (!regs.gradient_enable) begin
        rgb = regs.background_color;
      end else begin
        n = (i * 255) / lim;
        for (s = 0; s < 24; s += 8) begin
          g = regs.gradient_color[s +: 8];
          b = regs.background_color[s +: 8];
          rgb[s +: 8] = 8'((n * g + (255 - n) * b) / 255);
        end
      end
      w.red = rgb[23:16];
      w.green = rgb[15:8];
      w.blue = rgb[7:0];
      w.inside_set = !escaped;
      w.escape_count = 16'(i);
      return w;
    endfunction

    function void note_pixel(logic [13:0] col, logic [13:0] row);
      queued.push_back(escape_color(col, row));
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        fails++;
      end
    endfunction

    function void check_color(pixel_word_t got);
      pixel_word_t want;
      if (queued.size() == 0) begin
        $display("%0t: unexpected color word, got %h", $time, got);
        fails++;
      end else begin
        want = queued.pop_front();
        compare_field("red", want.red, got.red);
        compare_field("green", want.green, got.green);
        compare_field("blue", want.blue, got.blue);
        compare_field("inside_set", want.inside_set, got.inside_set);
        compare_field("escape_count", want.escape_count, got.escape_count);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [13:0] column = '0;
  logic [13:0] pixel_row = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  red, green, blue;
  logic        inside_set;
  logic [15:0] escape_count;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  color_scoreboard sb = new();

  int burst_left = 0;
  int pixels_sent = 0;
  int words_seen = 0;
  int hold_left = 0;
  int rx_tick = 0;
  int rx_style = 0;
  int idle_cycles = 0;

  logic [19:0] rand_step;

  mandelbrot_escape_pixel_color_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .column(column), .pixel_row(pixel_row),
    .out_valid(out_valid), .out_ready(out_ready),
    .red(red), .green(green), .blue(blue),
    .inside_set(inside_set), .escape_count(escape_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // apb write: setup then access, register copy follows the block
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(int'(idx) * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MAX_ITER: sb.regs.max_iterations = value[15:0];
      REG_GRAD_EN:  sb.regs.gradient_enable = value[0];
      REG_BODY:     sb.regs.body_color = value[23:0];
      REG_BG:       sb.regs.background_color = value[23:0];
      REG_GRAD:     sb.regs.gradient_color = value[23:0];
      REG_STEP:     sb.regs.pixel_step = value[19:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (sb.queued.size() != 0) @(posedge clk);
  endtask

  // settings change only once every expected word is back
  task automatic set_registers(logic [15:0] limit, logic grad_en, logic [23:0] body,
                               logic [23:0] bg, logic [23:0] grad, logic [19:0] step);
    wait_drained();
    write_reg(REG_MAX_ITER, 32'(limit));
    write_reg(REG_GRAD_EN, 32'(grad_en));
    write_reg(REG_BODY, 32'(body));
    write_reg(REG_BG, 32'(bg));
    write_reg(REG_GRAD, 32'(grad));
    write_reg(REG_STEP, 32'(step));
  endtask

  // one pixel word, sender idles between bursts of random length
  task automatic send_pixel(logic [13:0] col, logic [13:0] row);
    int gap;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 250) : $urandom_range(1, 20);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    in_valid <= 1'b1;
    column <= col;
    pixel_row <= row;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(col, row);
    burst_left--;
  endtask

  // mostly pixels around the set, some anywhere in the 14-bit range; far-only mode picks columns above 3072
  function automatic void pick_pixel(bit far_only, output logic [13:0] col,
                                     output logic [13:0] row);
    int unsigned step, span_c, span_r;
    step = sb.regs.pixel_step;
    if (far_only) begin
      col = 14'($urandom_range(3073, 16383));
      row = 14'($urandom);
    end else if (step == 0 || $urandom_range(0, 4) == 0) begin
      col = 14'($urandom);
      row = 14'($urandom);
    end else begin
      span_c = 32'((longint'(3) <<< FRAC_BITS) / step);
      span_r = 32'((longint'(5) <<< (FRAC_BITS - 1)) / step);
      if (span_c > 16383) span_c = 16383;
      if (span_r > 16383) span_r = 16383;
      col = 14'($urandom_range(0, span_c));
      row = 14'($urandom_range(0, span_r));
    end
  endfunction

  task automatic run_pixels(int count, bit far_only);
    logic [13:0] col, row;
    for (int k = 0; k < count; k++) begin
      pick_pixel(far_only, col, row);
      send_pixel(col, row);
      pixels_sent++;
    end
    in_valid <= 1'b0;
  endtask

  // receiver: changing stall styles plus long hold-offs to back up the block
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_color(pixel_word_t'({red, green, blue, inside_set, escape_count}));
      words_seen++;
      if (words_seen == 90 || words_seen == 400) hold_left = HOLD_CYCLES;
    end
    rx_tick++;
    if (rx_tick % 300 == 0) rx_style = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_style)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (rx_tick % 4 == 0);
        default: out_ready <= ((rx_tick / 16) % 2 == 0);
      endcase
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: corners, far and boundary points, cardioid and cusp
    send_pixel(14'd0, 14'd0);
    send_pixel(14'd16383, 14'd16383);
    send_pixel(14'd16383, 14'd0);
    send_pixel(14'd0, 14'd16383);
    send_pixel(14'd1024, 14'd512);
    send_pixel(14'd768, 14'd512);
    send_pixel(14'd0, 14'd512);
    send_pixel(14'd2048, 14'd512);
    send_pixel(14'd3072, 14'd512);
    send_pixel(14'd3073, 14'd512);
    send_pixel(14'd1024, 14'd2560);
    send_pixel(14'd1024, 14'd2561);
    send_pixel(14'd1024, 14'd0);
    send_pixel(14'h2AAA, 14'h1555);
    send_pixel(14'h1555, 14'h2AAA);
    send_pixel(14'd1152, 14'd512);
    in_valid <= 1'b0;

    // gradient blend over a range of escape indices
    set_registers(16'd255, 1'b1, 24'h123456, 24'hFFFFFF, 24'h000000, 20'd524288);
    send_pixel(14'd1200, 14'd512);
    send_pixel(14'd1160, 14'd512);
    send_pixel(14'd1400, 14'd512);
    send_pixel(14'd1100, 14'd900);
    send_pixel(14'd1024, 14'd512);
    in_valid <= 1'b0;

    // zero limit: every pixel is inside
    set_registers(16'd0, 1'b1, 24'($urandom), 24'($urandom), 24'($urandom), 20'd524288);
    run_pixels(20, 1'b0);
    // zero step: every pixel at the same point
    set_registers(16'd16, 1'b1, 24'($urandom), 24'($urandom), 24'($urandom), 20'd0);
    run_pixels(20, 1'b0);
    // widest step
    set_registers(16'd40, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'h000000, 20'hFFFFF);
    run_pixels(60, 1'b0);
    // largest limit, far pixels only
    set_registers(16'hFFFF, 1'b1, 24'($urandom), 24'($urandom), 24'($urandom), 20'd524288);
    run_pixels(20, 1'b1);
    // single iteration
    set_registers(16'd1, 1'b1, 24'($urandom), 24'($urandom), 24'($urandom), 20'd524288);
    run_pixels(40, 1'b0);
    // full blend weight range with extreme colors
    set_registers(16'd255, 1'b1, 24'h000000, 24'h000000, 24'hFFFFFF, 20'd524288);
    run_pixels(20, 1'b0);

    // random settings and pixels
    while (pixels_sent < RANDOM_PIXELS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: rand_step = 20'd524288;
        5, 6, 7:       rand_step = 20'($urandom_range(49156, 1048575));
        8:             rand_step = 20'($urandom_range(1, 4096));
        default:       rand_step = 20'd262144;
      endcase
      set_registers(16'($urandom_range(2, 48)), 1'($urandom_range(0, 1)),
                    24'($urandom), 24'($urandom), 24'($urandom), rand_step);
      run_pixels(60, 1'b0);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.fails == 0 && sb.queued.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
